### rtl/ffw_pkg.sv
// ----------------------------------------------------------------------------
// ffw_pkg
// Shared types and constants of the feedback freshness watchdog.
// ----------------------------------------------------------------------------
package ffw_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int SEQ_BITS_DEF  = 32;
  localparam int TIMEOUT_BITS  = 32;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [3:0] {
    RC_OK              = 4'd0,
    RC_UNVERIFIED      = 4'd1,
    RC_BAD_CLOCK       = 4'd2,
    RC_WAITING         = 4'd3,
    RC_BAD_STAMP       = 4'd4,
    RC_BACKWARD        = 4'd5,
    RC_MARKER_CHANGE   = 4'd6,
    RC_MARKER_BACKWARD = 4'd7,
    RC_RECV_TIMEOUT    = 4'd8,
    RC_STALLED         = 4'd9
  } reason_t;

  // status flags of the stream, kept between items
  typedef struct packed {
    logic seen_any;
    logic markers_valid;
    logic last_seq_present;
    logic last_src_present;
  } flags_t;

  typedef struct packed {
    logic    progressed;
    logic    healthy;
    reason_t reason;
  } result_t;

endpackage

### rtl/ffw_in_stage.sv
// ----------------------------------------------------------------------------
// ffw_in_stage
// Input register: captures one item per transfer and holds it until the
// evaluation stage takes it.
// ----------------------------------------------------------------------------
module ffw_in_stage #(
  parameter int TIME_BITS = ffw_pkg::TIME_BITS_DEF,
  parameter int SEQ_BITS  = ffw_pkg::SEQ_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [TIME_BITS-1:0] now_time,
  input  logic                 now_valid,
  input  logic                 seq_present,
  input  logic [SEQ_BITS-1:0]  seq_value,
  input  logic                 src_present,
  input  logic [TIME_BITS-1:0] src_time,
  input  logic                 src_valid,
  input  logic                 advance,
  output logic                 held,
  output logic                 h_op,
  output logic [TIME_BITS-1:0] h_now_time,
  output logic                 h_now_valid,
  output logic                 h_seq_present,
  output logic [SEQ_BITS-1:0]  h_seq_value,
  output logic                 h_src_present,
  output logic [TIME_BITS-1:0] h_src_time,
  output logic                 h_src_valid
);

  logic load;

  assign in_stall = held && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h_op          <= op;
      h_now_time    <= now_time;
      h_now_valid   <= now_valid;
      h_seq_present <= seq_present;
      h_seq_value   <= seq_value;
      h_src_present <= src_present;
      h_src_time    <= src_time;
      h_src_valid   <= src_valid;
    end
  end

endmodule

### rtl/ffw_eval.sv
// ----------------------------------------------------------------------------
// ffw_eval
// Single-pass evaluation of one item: stamp, clock and marker checks, next stream state and
// the health verdict taken against that next state.
// ----------------------------------------------------------------------------
module ffw_eval #(
  parameter int TIME_BITS = ffw_pkg::TIME_BITS_DEF,
  parameter int SEQ_BITS  = ffw_pkg::SEQ_BITS_DEF
) (
  input  logic                              op,
  input  logic [TIME_BITS-1:0]              now_time,
  input  logic                              now_valid,
  input  logic                              seq_present,
  input  logic [SEQ_BITS-1:0]               seq_value,
  input  logic                              src_present,
  input  logic [TIME_BITS-1:0]              src_time,
  input  logic                              src_valid,
  input  logic [ffw_pkg::TIMEOUT_BITS-1:0]  timeout_ticks,
  input  ffw_pkg::flags_t                   flags,
  input  ffw_pkg::reason_t                  latched_reason,
  input  logic [TIME_BITS-1:0]              last_receive_time,
  input  logic [TIME_BITS-1:0]              last_progress_time,
  input  logic [SEQ_BITS-1:0]               last_seq,
  input  logic [TIME_BITS-1:0]              last_src_time,
  output ffw_pkg::flags_t                   flags_next,
  output ffw_pkg::reason_t                  latched_reason_next,
  output logic [TIME_BITS-1:0]              last_receive_time_next,
  output logic [TIME_BITS-1:0]              last_progress_time_next,
  output logic [SEQ_BITS-1:0]               last_seq_next,
  output logic [TIME_BITS-1:0]              last_src_time_next,
  output ffw_pkg::result_t                  result
);
  import ffw_pkg::*;

  localparam int CMP_BITS = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

  logic                 bad_stamp;
  logic                 backward;
  logic                 marker_change;
  logic                 marker_back;
  logic                 repeated;
  logic                 progressed;
  logic [TIME_BITS-1:0] age_recv;
  logic [TIME_BITS-1:0] age_prog;
  logic [CMP_BITS-1:0]  timeout_ext;
  logic                 recv_late;
  logic                 prog_late;
  logic                 now_behind;
  reason_t              reason;

  assign bad_stamp     = !now_valid || (src_present && !src_valid);
  assign backward      = flags.seen_any && (now_time < last_receive_time);
  assign marker_change = flags.seen_any &&
                         ((seq_present != flags.last_seq_present) ||
                          (src_present != flags.last_src_present));
  assign marker_back   = flags.seen_any &&
                         ((seq_present && (seq_value < last_seq)) ||
                          (src_present && (src_time < last_src_time)));
  assign repeated      = flags.seen_any &&
                         ((seq_present && (seq_value == last_seq)) ||
                          (src_present && (src_time == last_src_time)));

  always_comb begin
    flags_next              = flags;
    latched_reason_next     = latched_reason;
    last_receive_time_next  = last_receive_time;
    last_progress_time_next = last_progress_time;
    last_seq_next           = last_seq;
    last_src_time_next      = last_src_time;
    progressed              = 1'b0;
    if (op) begin
      priority if (bad_stamp) begin
        flags_next.markers_valid = 1'b0;
        latched_reason_next      = RC_BAD_STAMP;
      end else if (backward) begin
        flags_next.markers_valid = 1'b0;
        latched_reason_next      = RC_BACKWARD;
      end else if (marker_change) begin
        flags_next.markers_valid = 1'b0;
        latched_reason_next      = RC_MARKER_CHANGE;
      end else begin
        // receive time moves even when the markers are then refused
        last_receive_time_next = now_time;
        priority if (marker_back) begin
          flags_next.markers_valid = 1'b0;
          latched_reason_next      = RC_MARKER_BACKWARD;
        end else if (repeated) begin
          progressed = 1'b0;
        end else begin
          flags_next.seen_any         = 1'b1;
          flags_next.markers_valid    = 1'b1;
          flags_next.last_seq_present = seq_present;
          flags_next.last_src_present = src_present;
          last_seq_next               = seq_present ? seq_value : '0;
          last_src_time_next          = src_present ? src_time : '0;
          last_progress_time_next     = now_time;
          latched_reason_next         = RC_OK;
          progressed                  = 1'b1;
        end
      end
    end
  end

  // progress time never runs ahead of receive time, so neither age wraps
  // once now is not behind the receive time
  assign age_recv    = now_time - last_receive_time_next;
  assign age_prog    = now_time - last_progress_time_next;
  assign timeout_ext = CMP_BITS'(timeout_ticks);
  assign now_behind  = now_time < last_receive_time_next;
  assign recv_late   = CMP_BITS'(age_recv) > timeout_ext;
  assign prog_late   = CMP_BITS'(age_prog) > timeout_ext;

  always_comb begin
    priority if (!now_valid) begin
      reason = RC_BAD_CLOCK;
    end else if (!flags_next.seen_any) begin
      reason = (latched_reason_next != RC_OK) ? latched_reason_next : RC_WAITING;
    end else if (!flags_next.markers_valid) begin
      reason = latched_reason_next;
    end else if (now_behind) begin
      reason = RC_BACKWARD;
    end else if (recv_late) begin
      reason = RC_RECV_TIMEOUT;
    end else if (prog_late) begin
      reason = RC_STALLED;
    end else if (flags_next.last_seq_present || flags_next.last_src_present) begin
      reason = RC_OK;
    end else begin
      reason = RC_UNVERIFIED;
    end
  end

  assign result.progressed = progressed;
  assign result.healthy    = flags_next.seen_any && flags_next.markers_valid && now_valid &&
                             !now_behind && !recv_late && !prog_late;
  assign result.reason     = reason;

endmodule

### rtl/feedback_freshness_watchdog_unit.sv
// ----------------------------------------------------------------------------
// feedback_freshness_watchdog_unit
// Freshness watchdog for a feedback stream: judges each tick or observation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item per transfer, op 0 for a
// health-check tick, op 1 for an observation with its optional markers.
// Output channel (out_valid/out_stall): one result per item, in order, with
// progressed, healthy and reason_code.
// cfg_we/cfg_wdata write timeout_ticks; write it only while the block is idle.
// An accepted item is held and evaluated in the input register; its result
// is registered in the result register as the item leaves and is offered there.
// Throughput: one item per cycle while out_stall is low. The stream state is
// updated in the same pass that produces the result, so each item sees the
// state left by the item before it.
// When out_stall holds, the result register keeps its item and the input
// register still takes one more item; in_stall rises once both are full.
// Reset clears the stream state (nothing seen, no latched reason), empties
// both registers and sets timeout_ticks to 1000.
// ----------------------------------------------------------------------------
module feedback_freshness_watchdog_unit #(
  parameter int TIME_BITS = ffw_pkg::TIME_BITS_DEF,
  parameter int SEQ_BITS  = ffw_pkg::SEQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffw_pkg::TIMEOUT_BITS-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [TIME_BITS-1:0]              now_time,
  input  logic                              now_valid,
  input  logic                              seq_present,
  input  logic [SEQ_BITS-1:0]               seq_value,
  input  logic                              src_present,
  input  logic [TIME_BITS-1:0]              src_time,
  input  logic                              src_valid,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              progressed,
  output logic                              healthy,
  output logic [3:0]                        reason_code
);
  import ffw_pkg::*;

  logic                    advance;
  logic                    fire;
  logic                    held;
  logic                    h_op;
  logic [TIME_BITS-1:0]    h_now_time;
  logic                    h_now_valid;
  logic                    h_seq_present;
  logic [SEQ_BITS-1:0]     h_seq_value;
  logic                    h_src_present;
  logic [TIME_BITS-1:0]    h_src_time;
  logic                    h_src_valid;

  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  flags_t                  flags;
  flags_t                  flags_next;
  reason_t                 latched_reason;
  reason_t                 latched_reason_next;
  logic [TIME_BITS-1:0]    last_receive_time;
  logic [TIME_BITS-1:0]    last_receive_time_next;
  logic [TIME_BITS-1:0]    last_progress_time;
  logic [TIME_BITS-1:0]    last_progress_time_next;
  logic [SEQ_BITS-1:0]     last_seq;
  logic [SEQ_BITS-1:0]     last_seq_next;
  logic [TIME_BITS-1:0]    last_src_time;
  logic [TIME_BITS-1:0]    last_src_time_next;
  result_t                 result;

  assign advance = !out_valid || !out_stall;
  assign fire    = held && advance;

  ffw_in_stage #(
    .TIME_BITS (TIME_BITS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .now_time      (now_time),
    .now_valid     (now_valid),
    .seq_present   (seq_present),
    .seq_value     (seq_value),
    .src_present   (src_present),
    .src_time      (src_time),
    .src_valid     (src_valid),
    .advance       (advance),
    .held          (held),
    .h_op          (h_op),
    .h_now_time    (h_now_time),
    .h_now_valid   (h_now_valid),
    .h_seq_present (h_seq_present),
    .h_seq_value   (h_seq_value),
    .h_src_present (h_src_present),
    .h_src_time    (h_src_time),
    .h_src_valid   (h_src_valid)
  );

  ffw_eval #(
    .TIME_BITS (TIME_BITS),
    .SEQ_BITS  (SEQ_BITS)
  ) u_eval (
    .op                      (h_op),
    .now_time                (h_now_time),
    .now_valid               (h_now_valid),
    .seq_present             (h_seq_present),
    .seq_value               (h_seq_value),
    .src_present             (h_src_present),
    .src_time                (h_src_time),
    .src_valid               (h_src_valid),
    .timeout_ticks           (timeout_ticks),
    .flags                   (flags),
    .latched_reason          (latched_reason),
    .last_receive_time       (last_receive_time),
    .last_progress_time      (last_progress_time),
    .last_seq                (last_seq),
    .last_src_time           (last_src_time),
    .flags_next              (flags_next),
    .latched_reason_next     (latched_reason_next),
    .last_receive_time_next  (last_receive_time_next),
    .last_progress_time_next (last_progress_time_next),
    .last_seq_next           (last_seq_next),
    .last_src_time_next      (last_src_time_next),
    .result                  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  // stream state moves only when an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags              <= '0;
      latched_reason     <= RC_OK;
      last_receive_time  <= '0;
      last_progress_time <= '0;
      last_seq           <= '0;
      last_src_time      <= '0;
    end else if (fire) begin
      flags              <= flags_next;
      latched_reason     <= latched_reason_next;
      last_receive_time  <= last_receive_time_next;
      last_progress_time <= last_progress_time_next;
      last_seq           <= last_seq_next;
      last_src_time      <= last_src_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      progressed  <= result.progressed;
      healthy     <= result.healthy;
      reason_code <= 4'(result.reason);
    end
  end

  // fresh progress leaves both ages at zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && progressed |-> healthy)
    else $error("progressed result not healthy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && healthy |->
      (reason_code == 4'(RC_OK)) || (reason_code == 4'(RC_UNVERIFIED)))
    else $error("healthy result with a fault reason");

  assert property (@(posedge clk) disable iff (rst)
    flags.seen_any |=> flags.seen_any)
    else $error("seen flag cleared without reset");

  assert property (@(posedge clk) disable iff (rst)
    flags.markers_valid |-> flags.seen_any && (latched_reason == RC_OK))
    else $error("markers valid with latched reason or before first observation");

endmodule

### verif/ffw_checker.sv
// ----------------------------------------------------------------------------
// ffw_checker
// Watches both channels of the freshness watchdog and predicts every verdict.
// Each input transfer runs through a model of the stream state (seen, marker
// validity, latched reason, last receive/progress times, stored markers) and
// the verdict is queued; each output transfer is compared field by field
// with the oldest queued verdict.
// ----------------------------------------------------------------------------
module ffw_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ffw_pkg::TIMEOUT_BITS-1:0] cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             op,
  input  logic [31:0]                      now_time,
  input  logic                             now_valid,
  input  logic                             seq_present,
  input  logic [31:0]                      seq_value,
  input  logic                             src_present,
  input  logic [31:0]                      src_time,
  input  logic                             src_valid,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             progressed,
  input  logic                             healthy,
  input  logic [3:0]                       reason_code,
  output int                               mismatches,
  output int                               verdicts_checked,
  output int                               verdicts_owed
);
  import ffw_pkg::*;

  // predicted stream state
  logic        seen;
  logic        marks_ok;
  reason_t     latched;
  logic [31:0] last_rx;
  logic [31:0] last_prog;
  logic [31:0] last_seq;
  logic        seq_on;
  logic [31:0] last_src;
  logic        src_on;
  logic [31:0] limit_ticks;

  result_t     owed_verdicts[$];
  result_t     want;

  function automatic void latch_fault(reason_t why);
    marks_ok = 1'b0;
    latched  = why;
  endfunction

  function automatic result_t advance_watchdog(logic is_obs, logic [31:0] now, logic now_ok,
                                               logic sp, logic [31:0] sv, logic tp,
                                               logic [31:0] tv, logic t_ok);
    result_t v;
    logic    moved;
    moved = 1'b0;
    if (is_obs) begin
      if (!now_ok || (tp && !t_ok)) begin
        latch_fault(RC_BAD_STAMP);
      end else if (seen && now < last_rx) begin
        latch_fault(RC_BACKWARD);
      end else if (seen && (sp != seq_on || tp != src_on)) begin
        latch_fault(RC_MARKER_CHANGE);
      end else begin
        // receive time moves even if the markers are then refused
        last_rx = now;
        if (seen && ((sp && sv < last_seq) || (tp && tv < last_src))) begin
          latch_fault(RC_MARKER_BACKWARD);
        end else if (!(seen && ((sp && sv == last_seq) || (tp && tv == last_src)))) begin
          seq_on    = sp;
          last_seq  = sp ? sv : '0;
          src_on    = tp;
          last_src  = tp ? tv : '0;
          last_prog = now;
          seen      = 1'b1;
          marks_ok  = 1'b1;
          latched   = RC_OK;
          moved     = 1'b1;
        end
      end
    end
    v.progressed = moved;
    v.healthy    = seen && marks_ok && now_ok && now >= last_rx &&
                   (now - last_rx) <= limit_ticks && (now - last_prog) <= limit_ticks;
    if (!now_ok)                         v.reason = RC_BAD_CLOCK;
    else if (!seen)                      v.reason = (latched != RC_OK) ? latched : RC_WAITING;
    else if (!marks_ok)                  v.reason = latched;
    else if (now < last_rx)              v.reason = RC_BACKWARD;
    else if (now - last_rx > limit_ticks)   v.reason = RC_RECV_TIMEOUT;
    else if (now - last_prog > limit_ticks) v.reason = RC_STALLED;
    else                                 v.reason = (seq_on || src_on) ? RC_OK : RC_UNVERIFIED;
    return v;
  endfunction

  function automatic void compare_field(string what, logic [3:0] exp_v, logic [3:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seen        = 1'b0;
      marks_ok    = 1'b0;
      latched     = RC_OK;
      last_rx     = '0;
      last_prog   = '0;
      last_seq    = '0;
      seq_on      = 1'b0;
      last_src    = '0;
      src_on      = 1'b0;
      limit_ticks = TIMEOUT_RESET;
      owed_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, got progressed %0d healthy %0d reason %0d",
                   $time, progressed, healthy, reason_code);
        end else begin
          want = owed_verdicts.pop_front();
          compare_field("progressed", {3'b0, want.progressed}, {3'b0, progressed});
          compare_field("healthy", {3'b0, want.healthy}, {3'b0, healthy});
          compare_field("reason_code", want.reason, reason_code);
          verdicts_checked++;
        end
      end
      if (in_valid && !in_stall)
        owed_verdicts.push_back(advance_watchdog(op, now_time, now_valid, seq_present, seq_value,
                                                 src_present, src_time, src_valid));
      if (cfg_we)
        limit_ticks = cfg_wdata;
    end
    verdicts_owed <= owed_verdicts.size();
  end

endmodule

### verif/tb_feedback_freshness_watchdog_unit.sv
// ----------------------------------------------------------------------------
// tb_feedback_freshness_watchdog_unit
// Stimulus and verdict for the feedback freshness watchdog.
// A short directed sequence walks through every reason code the chosen marker
// pattern allows, then random phases run under several timeouts (zero, one,
// small, medium, all-ones) with mostly well-formed observation streams mixed
// with ticks, repeats, backward clocks and markers, bad stamps and noise.
// Both sides idle at random; one long receiver hold and one sender drain per
// phase. Checking is done by ffw_checker.
// ----------------------------------------------------------------------------
module tb_feedback_freshness_watchdog_unit;
  import ffw_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic        now_ok;
    logic        sp;
    logic [31:0] sv;
    logic        tp;
    logic [31:0] tv;
    logic        t_ok;
  } feed_t;

  localparam int ITEMS_PER_PHASE = 330;
  localparam int HOLD_CYCLES     = 48;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [TIMEOUT_BITS-1:0] cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    op;
  logic [31:0]             now_time;
  logic                    now_valid;
  logic                    seq_present;
  logic [31:0]             seq_value;
  logic                    src_present;
  logic [31:0]             src_time;
  logic                    src_valid;
  logic                    out_valid;
  logic                    out_stall;
  logic                    progressed;
  logic                    healthy;
  logic [3:0]              reason_code;

  int mismatches;
  int verdicts_checked;
  int verdicts_owed;

  logic        calm;          // receiver: no random stalls while set
  int          calm_left;     // sender: items left without gaps
  int          hold_asks;
  int          hold_served;
  logic        pat_sp;
  logic        pat_tp;
  logic [31:0] cur_now;
  logic [31:0] cur_seq;
  logic [31:0] cur_src;
  logic [31:0] cur_limit;
  int          items_sent;
  int          obs_sent;
  int          settings_used;

  feedback_freshness_watchdog_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .now_time    (now_time),
    .now_valid   (now_valid),
    .seq_present (seq_present),
    .seq_value   (seq_value),
    .src_present (src_present),
    .src_time    (src_time),
    .src_valid   (src_valid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .progressed  (progressed),
    .healthy     (healthy),
    .reason_code (reason_code)
  );

  ffw_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .now_time         (now_time),
    .now_valid        (now_valid),
    .seq_present      (seq_present),
    .seq_value        (seq_value),
    .src_present      (src_present),
    .src_time         (src_time),
    .src_valid        (src_valid),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .progressed       (progressed),
    .healthy          (healthy),
    .reason_code      (reason_code),
    .mismatches       (mismatches),
    .verdicts_checked (verdicts_checked),
    .verdicts_owed    (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall before each transfer, long holds on request
  initial begin
    int n;
    out_stall   <= 1'b0;
    hold_served = 0;
    forever begin
      if (hold_asks != hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        n = calm ? 0 : $urandom_range(11, 0);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic feed(feed_t it);
    int gap;
    gap = (calm_left != 0) ? 0 : $urandom_range(11, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= it.op;
    now_time    <= it.now;
    now_valid   <= it.now_ok;
    seq_present <= it.sp;
    seq_value   <= it.sv;
    src_present <= it.tp;
    src_time    <= it.tv;
    src_valid   <= it.t_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.op) obs_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  task automatic set_limit(logic [31:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
    settings_used++;
  endtask

  // well-formed observation in the stream's marker pattern; absent markers junk
  function automatic feed_t observation(logic [31:0] t, logic [31:0] s, logic [31:0] ts);
    feed_t it;
    it.op     = 1'b1;
    it.now    = t;
    it.now_ok = 1'b1;
    it.sp     = pat_sp;
    it.sv     = pat_sp ? s : $urandom();
    it.tp     = pat_tp;
    it.tv     = pat_tp ? ts : $urandom();
    it.t_ok   = pat_tp ? 1'b1 : 1'($urandom_range(1, 0));
    return it;
  endfunction

  function automatic feed_t health_tick(logic [31:0] t, logic ok);
    feed_t it;
    it.op     = 1'b0;
    it.now    = t;
    it.now_ok = ok;
    it.sp     = 1'($urandom_range(1, 0));
    it.sv     = $urandom();
    it.tp     = 1'($urandom_range(1, 0));
    it.tv     = $urandom();
    it.t_ok   = 1'($urandom_range(1, 0));
    return it;
  endfunction

  // time advance shaped around the current timeout
  function automatic logic [31:0] time_step();
    logic [31:0] lim;
    int          pick;
    lim  = (cur_limit > 32'd3000) ? 32'd3000 : cur_limit;
    pick = $urandom_range(99, 0);
    if (pick < 60)      return $urandom_range(lim, 0);
    else if (pick < 85) return lim + $urandom_range(lim / 2 + 2, 0);
    else                return lim + $urandom_range(1, 0);
  endfunction

  task automatic directed_items();
    feed_t it;
    feed(health_tick(32'd5, 1'b1));                    // nothing seen yet
    feed(health_tick(32'd0, 1'b0));                    // invalid local clock
    it = observation(32'd3, 32'd100, 32'd1000);
    it.now_ok = 1'b0;
    feed(it);                                          // refused before first take
    feed(health_tick(32'd4, 1'b1));
    feed(observation(32'd10, 32'd100, 32'd1000));
    feed(health_tick(32'd10, 1'b1));
    feed(observation(32'd20, 32'd100, 32'd1000));      // repeated markers
    feed(observation(32'd30, 32'd99, 32'd999));        // markers step back
    feed(health_tick(32'd31, 1'b1));
    it = observation(32'd35, 32'd101, 32'd1001);
    it.sp = ~it.sp;
    feed(it);                                          // presence changes
    it = observation(32'd36, 32'd101, 32'd1001);
    it.tp   = 1'b1;
    it.t_ok = 1'b0;
    feed(it);                                          // bad source stamp
    feed(observation(32'd5, 32'd101, 32'd1001));       // clock backward
    feed(observation(32'd40, 32'd101, 32'd1001));
    feed(health_tick(32'd39, 1'b1));
    feed(health_tick(32'd1040, 1'b1));                 // age exactly at limit
    feed(health_tick(32'd1041, 1'b1));
    feed(observation(32'd1100, 32'd101, 32'd1002));    // receive without progress when seq is present
    feed(health_tick(32'd1100, 1'b1));
    it = health_tick('1, 1'b1);
    it.sp   = 1'b1;
    it.sv   = '1;
    it.tp   = 1'b1;
    it.tv   = '1;
    it.t_ok = 1'b1;
    feed(it);
    it.op     = 1'b1;
    it.now_ok = 1'b0;
    feed(it);
    feed(observation(32'd1150, 32'd102, 32'd1003));
    cur_now = 32'd1150;
    cur_seq = 32'd102;
    cur_src = 32'd1003;
  endtask

  task automatic random_item();
    feed_t it;
    int    pick;
    pick = $urandom_range(99, 0);
    if (pick < 50) begin
      cur_now += time_step();
      cur_seq += $urandom_range(3, 1);
      cur_src += $urandom_range(40, 1);
      it = observation(cur_now, cur_seq, cur_src);
    end else if (pick < 60) begin
      cur_now += time_step();
      case ($urandom_range(2, 0))
        0:       it = observation(cur_now, cur_seq, cur_src + 1);
        1:       it = observation(cur_now, cur_seq + 1, cur_src);
        default: it = observation(cur_now, cur_seq, cur_src);
      endcase
    end else if (pick < 80) begin
      it = health_tick(cur_now + time_step(), 1'b1);
      if ($urandom_range(1, 0) != 0) it.now = it.now + time_step();
      if ($urandom_range(9, 0) == 0)      it.now_ok = 1'b0;
      else if ($urandom_range(9, 0) == 0) it.now = cur_now - $urandom_range(3, 1);
    end else if (pick < 86) begin
      cur_now += time_step();
      if ($urandom_range(1, 0) != 0) it = observation(cur_now, cur_seq - 1, cur_src + 1);
      else                           it = observation(cur_now, cur_seq + 1, cur_src - 1);
    end else if (pick < 90) begin
      it = observation(cur_now + time_step(), cur_seq + 1, cur_src + 1);
      if ($urandom_range(1, 0) != 0) it.sp = ~it.sp;
      else                           it.tp = ~it.tp;
      it.t_ok = 1'b1;
    end else if (pick < 94) begin
      it = observation(cur_now + time_step(), cur_seq + 1, cur_src + 1);
      if ($urandom_range(1, 0) != 0) begin
        it.now_ok = 1'b0;
      end else begin
        it.tp   = 1'b1;
        it.t_ok = 1'b0;
      end
    end else if (pick < 97) begin
      it = observation(cur_now - $urandom_range(4, 1), cur_seq + 1, cur_src + 1);
    end else begin
      // noise: any tick, or an observation refused for its clock
      it.op     = 1'($urandom_range(1, 0));
      it.now    = $urandom();
      it.now_ok = 1'($urandom_range(1, 0));
      it.sp     = 1'($urandom_range(1, 0));
      it.sv     = $urandom();
      it.tp     = 1'($urandom_range(1, 0));
      it.tv     = $urandom();
      it.t_ok   = 1'($urandom_range(1, 0));
      if (it.op) it.now_ok = 1'b0;
    end
    feed(it);
  endtask

  initial begin
    logic [31:0] limits[5];
    int          pick;
    in_valid    <= 1'b0;
    op          <= 1'b0;
    now_time    <= '0;
    now_valid   <= 1'b0;
    seq_present <= 1'b0;
    seq_value   <= '0;
    src_present <= 1'b0;
    src_time    <= '0;
    src_valid   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    calm        <= 1'b0;
    rst         <= 1'b1;
    calm_left     = 0;
    items_sent    = 0;
    obs_sent      = 0;
    settings_used = 1;
    cur_limit     = TIMEOUT_RESET;

    // the first accepted observation fixes the marker pattern for good
    pick = $urandom_range(4, 0);
    pat_sp = (pick != 3 && pick != 4);
    pat_tp = (pick != 2 && pick != 4);

    limits[0] = 32'd0;
    limits[1] = 32'd1;
    limits[2] = $urandom_range(64, 2);
    limits[3] = $urandom_range(5000, 100);
    limits[4] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();

    for (int p = 0; p < 5; p++) begin
      set_limit(limits[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == 150) begin
          hold_asks <= hold_asks + 1;
          calm_left = 30;
        end else if (k == 250) begin
          wait_drained();
        end else if (calm_left == 0 && $urandom_range(59, 0) == 0) begin
          calm_left = $urandom_range(40, 10);
        end
        if (calm_left != 0) calm_left--;
        calm <= (calm_left != 0);
        random_item();
      end
    end

    // largest values last, since time and markers never go back afterwards
    feed(observation('1, '1, '1));
    feed(health_tick('1, 1'b1));

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Covered %0d items (%0d observations) over %0d timeout settings, zero and all-ones included;",
             items_sent, obs_sent, settings_used);
    $display("%0d verdicts compared, marker pattern seq %0b src %0b", verdicts_checked, pat_sp, pat_tp);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
